// ----- rtl/core/c2d_pkg.sv -----
// Package with shared types and constants of the multi-channel convolution block.
package c2d_pkg;

    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_PIXEL   = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;
    localparam logic [1:0] OP_INVALID = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_GEOM  = 2'd2;

    localparam logic [2:0] REG_IN_CH   = 3'd0;
    localparam logic [2:0] REG_OUT_CH  = 3'd1;
    localparam logic [2:0] REG_KERNEL  = 3'd2;
    localparam logic [2:0] REG_STRIDE  = 3'd3;
    localparam logic [2:0] REG_PADDING = 3'd4;
    localparam logic [2:0] REG_HEIGHT  = 3'd5;
    localparam logic [2:0] REG_WIDTH   = 3'd6;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         out_chan;
        logic [2:0]         in_chan;
        logic [5:0]         row_index;
        logic [4:0]         col_index;
        logic signed [15:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]         res_chan;
        logic [5:0]         res_row;
        logic [5:0]         res_col;
        logic signed [31:0] result;
        logic [1:0]         status;
        logic               last;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  index;
        logic [5:0]  data;
    } t_cfg;

endpackage

// ----- rtl/core/c2d_if.sv -----
// Valid/ready channel interface carrying one payload.
interface c2d_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/c2d_mem.sv -----
// Synchronous single-port-write, single-read memory with registered read data.
module c2d_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [15:0]       i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [15:0]       o_rdata
);
    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/c2d_mac.sv -----
// Multiply-accumulate datapath: registered product, exact sum and saturation.
module c2d_mac #(
    parameter int AccW = 48
) (
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic               i_en,
    input  logic signed [15:0] i_w,
    input  logic signed [15:0] i_x,
    output logic signed [31:0] o_sat
);
    logic signed [31:0]     r_prod;
    logic signed [AccW-1:0] r_acc;
    logic signed [AccW-1:0] w_max, w_min;

    assign w_max = AccW'(32'sh7FFF_FFFF);
    assign w_min = -w_max - AccW'(1);

    always_ff @(posedge i_clk) begin
        r_prod <= i_en ? i_w * i_x : 32'sd0;
        if (i_clear) begin
            r_acc <= '0;
        end else begin
            r_acc <= r_acc + AccW'(r_prod);
        end
    end

    always_comb begin
        if (r_acc > w_max) begin
            o_sat = 32'sh7FFF_FFFF;
        end else if (r_acc < w_min) begin
            o_sat = 32'sh8000_0000;
        end else begin
            o_sat = r_acc[31:0];
        end
    end
endmodule

// ----- rtl/core/conv2d_multichannel.sv -----
// Top level of the multi-channel strided, zero-padded 2D convolution block.
// Usage: requests arrive on i_req (op, channels, row, column, value). A weight
// or pixel write request stores its value in the weight or pixel memory when
// its indices are in range and returns one acknowledge on o_rsp. A compute
// request names an output channel and output row; the block returns one
// response per output column, in column order, with last on the final one.
// Configuration registers are written over i_cfg; the user must write them only
// while the block idles, which the block itself does not enforce.
// A compute request walks every tap (in_channels x kernel x kernel) once per
// output column, one memory read per cycle, then drains the read, multiply
// and accumulate stages before each column's response; 392 taps per column
// at the largest geometry.
// Taps outside the image are still visited, with the product forced to zero.
// One request is in work at a time; the request ready drops until the last
// response of the current request has been taken.
// A stalled receiver holds the response register; the sequencer waits.
// Reset restores the register defaults; the memories stay undefined until
// written and need no clearing pass.
module conv2d_multichannel #(
    parameter int MAX_IN_CH  = 8,
    parameter int MAX_OUT_CH = 8,
    parameter int MAX_KERNEL = 7,
    parameter int MAX_DIM    = 32,
    parameter int MAX_PAD    = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    c2d_if.sink   i_req,
    c2d_if.sink   i_cfg,
    c2d_if.source o_rsp
);
    localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int PDEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
    localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int PAW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TAP   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_EMIT  = 6'b001000,
        S_ACK   = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers, raw bits.
    logic [3:0] r_nic, r_noc;
    logic [2:0] r_k, r_s;
    logic [1:0] r_pad;
    logic [5:0] r_ih, r_iw;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nic <= 4'd3; r_noc <= 4'd6; r_k <= 3'd3; r_s <= 3'd1;
            r_pad <= 2'd0; r_ih <= 6'd7; r_iw <= 6'd7;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_IN_CH_C:   r_nic <= i_cfg.data.data[3:0];
                REG_OUT_CH_C:  r_noc <= i_cfg.data.data[3:0];
                REG_KERNEL_C:  r_k   <= i_cfg.data.data[2:0];
                REG_STRIDE_C:  r_s   <= i_cfg.data.data[2:0];
                REG_PADDING_C: r_pad <= i_cfg.data.data[1:0];
                REG_HEIGHT_C:  r_ih  <= i_cfg.data.data[5:0];
                REG_WIDTH_C:   r_iw  <= i_cfg.data.data[5:0];
                default: ;
            endcase
        end
    end
    localparam logic [2:0] REG_IN_CH_C   = c2d_pkg::REG_IN_CH;
    localparam logic [2:0] REG_OUT_CH_C  = c2d_pkg::REG_OUT_CH;
    localparam logic [2:0] REG_KERNEL_C  = c2d_pkg::REG_KERNEL;
    localparam logic [2:0] REG_STRIDE_C  = c2d_pkg::REG_STRIDE;
    localparam logic [2:0] REG_PADDING_C = c2d_pkg::REG_PADDING;
    localparam logic [2:0] REG_HEIGHT_C  = c2d_pkg::REG_HEIGHT;
    localparam logic [2:0] REG_WIDTH_C   = c2d_pkg::REG_WIDTH;

    // Effective (clamped) geometry, 16-bit working values.
    function automatic logic [15:0] clamp(input logic [15:0] v, input logic [15:0] lo,
                                          input logic [15:0] hi);
        logic [15:0] t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    logic [15:0] e_nic, e_noc, e_k, e_s, e_pad, e_ih, e_iw, e_ph, e_pw;
    assign e_nic = clamp(16'(r_nic), 16'd1, 16'(MAX_IN_CH));
    assign e_noc = clamp(16'(r_noc), 16'd1, 16'(MAX_OUT_CH));
    assign e_k   = clamp(16'(r_k), 16'd1, 16'(MAX_KERNEL));
    assign e_s   = clamp(16'(r_s), 16'd1, 16'd7);
    assign e_pad = clamp(16'(r_pad), 16'd0, 16'(MAX_PAD));
    assign e_ih  = clamp(16'(r_ih), 16'd1, 16'(MAX_DIM));
    assign e_iw  = clamp(16'(r_iw), 16'd1, 16'(MAX_DIM));
    assign e_ph  = e_ih + (e_pad << 1);
    assign e_pw  = e_iw + (e_pad << 1);

    // Output row/column counts: (p - k) / s + 1, computed by a small loop of
    // subtractions over at most seven strides would be long; instead compare
    // the window start against the padded extent: position r is valid when
    // r*s + k <= p.
    logic c_geom_bad;
    assign c_geom_bad = (e_ph < e_k) || (e_pw < e_k);

    c2d_pkg::t_req r_req;
    logic [15:0] r_col, r_j, r_zr, r_zc, r_rowbase, r_colbase;
    logic [2:0]  r_drain;
    c2d_pkg::t_rsp r_rsp;
    logic        r_rsp_v;

    // Tap address generation.
    logic signed [16:0] c_pr, c_pc;
    logic               c_in;
    assign c_pr = $signed({1'b0, r_rowbase + r_zr}) - $signed({1'b0, e_pad});
    assign c_pc = $signed({1'b0, r_colbase + r_zc}) - $signed({1'b0, e_pad});
    assign c_in = (c_pr >= 0) && (c_pr < $signed({1'b0, e_ih}))
               && (c_pc >= 0) && (c_pc < $signed({1'b0, e_iw}));

    logic [WAW-1:0] c_wr_waddr, c_rd_waddr;
    logic [PAW-1:0] c_wr_paddr, c_rd_paddr;
    assign c_wr_waddr = WAW'(((32'(i_req.data.out_chan) * MAX_IN_CH + 32'(i_req.data.in_chan))
                        * MAX_KERNEL + 32'(i_req.data.row_index)) * MAX_KERNEL
                        + 32'(i_req.data.col_index));
    assign c_wr_paddr = PAW'((32'(i_req.data.in_chan) * MAX_DIM + 32'(i_req.data.row_index))
                        * MAX_DIM + 32'(i_req.data.col_index));
    assign c_rd_waddr = WAW'(((32'(r_req.out_chan) * MAX_IN_CH + 32'(r_j)) * MAX_KERNEL
                        + 32'(r_zr)) * MAX_KERNEL + 32'(r_zc));
    assign c_rd_paddr = PAW'((32'(r_j) * MAX_DIM + 32'(c_pr[15:0])) * MAX_DIM
                        + 32'(c_pc[15:0]));

    logic c_acc;
    assign c_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_v;

    logic c_wok, c_pok, c_we_w, c_we_p;
    assign c_wok = (16'(i_req.data.out_chan) < e_noc) && (16'(i_req.data.in_chan) < e_nic)
                && (16'(i_req.data.row_index) < e_k) && (16'(i_req.data.col_index) < e_k);
    assign c_pok = (16'(i_req.data.in_chan) < e_nic) && (16'(i_req.data.row_index) < e_ih)
                && (16'(i_req.data.col_index) < e_iw);
    assign c_we_w = c_acc && (i_req.data.op == c2d_pkg::OP_WEIGHT) && c_wok;
    assign c_we_p = c_acc && (i_req.data.op == c2d_pkg::OP_PIXEL) && c_pok;

    logic [15:0] w_wd, w_pd;
    c2d_mem #(.DEPTH(WDEPTH), .AW(WAW)) u_wmem (
        .i_clk(i_clk), .i_we(c_we_w), .i_waddr(c_wr_waddr), .i_wdata(i_req.data.value),
        .i_raddr(c_rd_waddr), .o_rdata(w_wd));
    c2d_mem #(.DEPTH(PDEPTH), .AW(PAW)) u_pmem (
        .i_clk(i_clk), .i_we(c_we_p), .i_waddr(c_wr_paddr), .i_wdata(i_req.data.value),
        .i_raddr(c_in ? c_rd_paddr : '0), .o_rdata(w_pd));

    // Tap valid delayed to match memory read latency.
    logic r_tap_v, r_clear;
    logic signed [31:0] w_sat;
    c2d_mac #(.AccW(48)) u_mac (
        .i_clk(i_clk), .i_clear(r_clear), .i_en(r_tap_v),
        .i_w(w_wd), .i_x(w_pd), .o_sat(w_sat));

    logic c_last_tap, c_last_col;
    assign c_last_tap = (r_zc + 16'd1 == e_k) && (r_zr + 16'd1 == e_k) && (r_j + 16'd1 == e_nic);
    assign c_last_col = (r_colbase + e_s + e_k) > e_pw;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (c_acc) begin
                n_state = (i_req.data.op == c2d_pkg::OP_COMPUTE) ? S_WAIT : S_ACK;
            end
            S_WAIT:  n_state = S_TAP;
            S_TAP:   if (c_last_tap) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 3'd3) n_state = S_EMIT;
            S_EMIT:  if (!r_rsp_v) n_state = c_last_col ? S_IDLE : S_TAP;
            S_ACK:   if (!r_rsp_v) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp_v <= 1'b0;
            r_tap_v <= 1'b0;
            r_clear <= 1'b0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_tap_v <= (r_state == S_TAP) && c_in;
            r_clear <= 1'b0;
            if (o_rsp.valid && o_rsp.ready) r_rsp_v <= 1'b0;
            if (r_state == S_DRAIN) r_drain <= r_drain + 3'd1;
            else r_drain <= '0;

            if (r_state == S_IDLE && c_acc) begin
                r_req       <= i_req.data;
                r_rsp.res_chan <= (i_req.data.op == c2d_pkg::OP_PIXEL)
                                  ? i_req.data.in_chan : i_req.data.out_chan;
                r_rsp.res_row  <= i_req.data.row_index;
                r_rsp.res_col  <= 6'(i_req.data.col_index);
                r_rsp.result   <= '0;
                r_rsp.last     <= 1'b1;
                r_rsp.status   <= c_wok ? c2d_pkg::ST_OK : c2d_pkg::ST_RANGE;
                if (i_req.data.op == c2d_pkg::OP_PIXEL)
                    r_rsp.status <= c_pok ? c2d_pkg::ST_OK : c2d_pkg::ST_RANGE;
                if (i_req.data.op == c2d_pkg::OP_INVALID) begin
                    r_rsp.res_chan <= '0; r_rsp.res_row <= '0; r_rsp.res_col <= '0;
                    r_rsp.status   <= c2d_pkg::ST_RANGE;
                end
                r_rowbase <= 16'(i_req.data.row_index) * e_s;
                r_colbase <= '0; r_col <= '0;
                r_j <= '0; r_zr <= '0; r_zc <= '0;
                r_clear <= 1'b1;
            end
            if (r_state == S_WAIT) begin
                // Validate compute geometry; an error turns into a single acknowledge.
                if (c_geom_bad) begin
                    r_rsp.status <= c2d_pkg::ST_GEOM; r_rsp.res_col <= '0;
                    r_rsp_v <= 1'b1; r_state <= S_IDLE;
                end else if ((16'(r_req.out_chan) >= e_noc) || (r_rowbase + e_k > e_ph)) begin
                    r_rsp.status <= c2d_pkg::ST_RANGE; r_rsp.res_col <= '0;
                    r_rsp_v <= 1'b1; r_state <= S_IDLE;
                end
            end
            if (r_state == S_ACK && !r_rsp_v) begin
                r_rsp_v <= 1'b1;
            end
            if (r_state == S_TAP) begin
                if (r_zc + 16'd1 == e_k) begin
                    r_zc <= '0;
                    if (r_zr + 16'd1 == e_k) begin
                        r_zr <= '0;
                        r_j  <= r_j + 16'd1;
                    end else r_zr <= r_zr + 16'd1;
                end else r_zc <= r_zc + 16'd1;
            end
            if (r_state == S_EMIT && !r_rsp_v) begin
                r_rsp.res_col <= r_col[5:0];
                r_rsp.result  <= w_sat;
                r_rsp.status  <= c2d_pkg::ST_OK;
                r_rsp.last    <= c_last_col;
                r_rsp_v       <= 1'b1;
                r_clear       <= 1'b1;
                r_j <= '0;
                r_col     <= r_col + 16'd1;
                r_colbase <= r_colbase + e_s;
            end
        end
    end

    // The request side is closed while a response waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_rsp_v |-> !i_req.ready)
        else $error("request accepted while response pending");
    // A response only leaves the drain through the emit state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> !$rose(r_rsp_v))
        else $error("response raised during drain");
    // No memory write happens while the compute walks its taps.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> !(c_we_w || c_we_p))
        else $error("store written during compute");
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the multi-channel strided, zero-padded 2D convolution block.
`timescale 1ns / 100ps

module tb;
    import c2d_pkg::*;

    // One stimulus row: the request and, where it is obvious, the response typed in.
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    c2d_if #(.T(t_req)) req_if ();
    c2d_if #(.T(t_cfg)) cfg_if ();
    c2d_if #(.T(t_rsp)) rsp_if ();

    conv2d_multichannel dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the block: the registers as written, the two memories, and which
    // entries have been written so that no compute ever reads an undefined entry.
    logic [5:0]  regs [7];
    logic [15:0] weights [3136];
    logic [15:0] pixels [8192];
    bit          weight_set [3136];
    bit          pixel_set [8192];

    t_rsp  pending_rsp [$];
    t_row  rows [$];
    int    errors = 0;
    int    n_reqs = 0;
    int    n_rsps = 0;
    int    n_rows_done = 0;
    int    tx_idle = 14;
    int    rx_idle = 72;
    int    hold_reqs = 0;
    int    hold_seen = 0;
    int    hold_left = 0;

    function automatic int unsigned eff(int idx, int unsigned lo, int unsigned hi);
        int unsigned v;
        v = regs[idx];
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic int widx(int oc, int ic, int r, int c);
        return ((oc * 8 + ic) * 7 + r) * 7 + c;
    endfunction

    function automatic int pidx(int ic, int r, int c);
        return (ic * 32 + r) * 32 + c;
    endfunction

    // Output rows and columns of the current geometry; returns 0 when the padded
    // image is smaller than the kernel.
    function automatic bit out_shape(output int nr, output int nc);
        int k, s, pad, ph, pw;
        k = eff(REG_KERNEL, 1, 7);
        s = eff(REG_STRIDE, 1, 7);
        pad = eff(REG_PADDING, 0, 3);
        ph = eff(REG_HEIGHT, 1, 32) + 2 * pad;
        pw = eff(REG_WIDTH, 1, 32) + 2 * pad;
        nr = 0;
        nc = 0;
        if (ph < k || pw < k) return 1'b0;
        nr = (ph - k) / s + 1;
        nc = (pw - k) / s + 1;
        return 1'b1;
    endfunction

    function automatic t_rsp mk_rsp(int ch, int r, int c, longint v, logic [1:0] st, bit l);
        t_rsp x;
        x.res_chan = ch[2:0];
        x.res_row = r[5:0];
        x.res_col = c[5:0];
        x.result = v[31:0];
        x.status = st;
        x.last = l;
        return x;
    endfunction

    // Works out the responses of one accepted request and updates the memories.
    function automatic void conv_predict(t_req q);
        int nic, noc, k, s, pad, ih, iw, nr, nc, pr, pc;
        bit ok;
        longint acc;
        nic = eff(REG_IN_CH, 1, 8);
        noc = eff(REG_OUT_CH, 1, 8);
        k = eff(REG_KERNEL, 1, 7);
        s = eff(REG_STRIDE, 1, 7);
        pad = eff(REG_PADDING, 0, 3);
        ih = eff(REG_HEIGHT, 1, 32);
        iw = eff(REG_WIDTH, 1, 32);
        case (q.op)
            OP_WEIGHT: begin
                ok = q.out_chan < noc && q.in_chan < nic && q.row_index < k
                     && q.col_index < k;
                if (ok) begin
                    weights[widx(q.out_chan, q.in_chan, q.row_index, q.col_index)] = q.value;
                    weight_set[widx(q.out_chan, q.in_chan, q.row_index, q.col_index)] = 1'b1;
                end
                pending_rsp.push_back(mk_rsp(q.out_chan, q.row_index, q.col_index, 0,
                                             ok ? ST_OK : ST_RANGE, 1'b1));
            end
            OP_PIXEL: begin
                ok = q.in_chan < nic && q.row_index < ih && q.col_index < iw;
                if (ok) begin
                    pixels[pidx(q.in_chan, q.row_index, q.col_index)] = q.value;
                    pixel_set[pidx(q.in_chan, q.row_index, q.col_index)] = 1'b1;
                end
                pending_rsp.push_back(mk_rsp(q.in_chan, q.row_index, q.col_index, 0,
                                             ok ? ST_OK : ST_RANGE, 1'b1));
            end
            OP_INVALID: pending_rsp.push_back(mk_rsp(0, 0, 0, 0, ST_RANGE, 1'b1));
            default: begin
                if (!out_shape(nr, nc)) begin
                    pending_rsp.push_back(mk_rsp(q.out_chan, q.row_index, 0, 0, ST_GEOM, 1'b1));
                end else if (q.out_chan >= noc || q.row_index >= nr) begin
                    pending_rsp.push_back(mk_rsp(q.out_chan, q.row_index, 0, 0, ST_RANGE, 1'b1));
                end else begin
                    n_rows_done++;
                    for (int c = 0; c < nc; c++) begin
                        acc = 0;
                        for (int j = 0; j < nic; j++)
                            for (int zr = 0; zr < k; zr++)
                                for (int zc = 0; zc < k; zc++) begin
                                    pr = q.row_index * s + zr - pad;
                                    pc = c * s + zc - pad;
                                    if (pr >= 0 && pr < ih && pc >= 0 && pc < iw)
                                        acc += longint'($signed(weights[widx(q.out_chan, j, zr, zc)]))
                                             * longint'($signed(pixels[pidx(j, pr, pc)]));
                                end
                        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                        pending_rsp.push_back(mk_rsp(q.out_chan, q.row_index, c, acc, ST_OK,
                                                     c == nc - 1));
                    end
                end
            end
        endcase
    endfunction

    // Finds a pixel of the image or a weight of filter oc that was never written,
    // and returns a write request that fills it.
    function automatic bit find_hole(int oc, output t_req q);
        int nic, k, ih, iw;
        nic = eff(REG_IN_CH, 1, 8);
        k = eff(REG_KERNEL, 1, 7);
        ih = eff(REG_HEIGHT, 1, 32);
        iw = eff(REG_WIDTH, 1, 32);
        q = '0;
        q.value = $urandom;
        q.out_chan = oc;
        for (int j = 0; j < nic; j++) begin
            for (int r = 0; r < ih; r++)
                for (int c = 0; c < iw; c++)
                    if (!pixel_set[pidx(j, r, c)]) begin
                        q.op = OP_PIXEL; q.in_chan = j; q.row_index = r; q.col_index = c;
                        return 1'b1;
                    end
            for (int r = 0; r < k; r++)
                for (int c = 0; c < k; c++)
                    if (!weight_set[widx(oc, j, r, c)]) begin
                        q.op = OP_WEIGHT; q.in_chan = j; q.row_index = r; q.col_index = c;
                        return 1'b1;
                    end
        end
        return 1'b0;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // Response side: random stalls, a long hold-off on request, and the checker.
    always @(posedge i_clk) begin
        t_rsp w;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (hold_reqs != hold_seen) begin
                hold_seen <= hold_reqs;
                hold_left <= 400;
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= $urandom_range(99) >= rx_idle;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                n_rsps++;
                if (pending_rsp.size() == 0) begin
                    report("response with nothing expected, result", rsp_if.data.result, 0);
                end else begin
                    w = pending_rsp.pop_front();
                    if (rsp_if.data.res_chan !== w.res_chan)
                        report("res_chan", rsp_if.data.res_chan, w.res_chan);
                    if (rsp_if.data.res_row !== w.res_row)
                        report("res_row", rsp_if.data.res_row, w.res_row);
                    if (rsp_if.data.res_col !== w.res_col)
                        report("res_col", rsp_if.data.res_col, w.res_col);
                    if (rsp_if.data.result !== w.result)
                        report("result", rsp_if.data.result, w.result);
                    if (rsp_if.data.status !== w.status)
                        report("status", rsp_if.data.status, w.status);
                    if (rsp_if.data.last !== w.last)
                        report("last", rsp_if.data.last, w.last);
                end
            end
        end
    end

    // Offers one request, waits for acceptance, then predicts it. With a typed
    // row the hand-written response replaces the predicted one.
    task automatic send(t_req q, bit typed = 1'b0, t_rsp want = '0);
        int depth;
        while ($urandom_range(99) < tx_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= q;
        do @(posedge i_clk); while (!req_if.ready);
        n_reqs++;
        depth = pending_rsp.size();
        conv_predict(q);
        if (typed) begin
            while (pending_rsp.size() > depth) void'(pending_rsp.pop_back());
            pending_rsp.push_back(want);
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_rsp.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [5:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{index: idx, data: v};
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_IN_CH, REG_OUT_CH: regs[idx] = v & 6'h0f;
            REG_KERNEL, REG_STRIDE: regs[idx] = v & 6'h07;
            REG_PADDING: regs[idx] = v & 6'h03;
            default: regs[idx] = v;
        endcase
    endtask

    // New geometry, only with the block idle. The memories keep their content.
    task automatic set_geometry(int nic, int noc, int k, int s, int p, int h, int w);
        drain();
        write_reg(REG_IN_CH, nic);
        write_reg(REG_OUT_CH, noc);
        write_reg(REG_KERNEL, k);
        write_reg(REG_STRIDE, s);
        write_reg(REG_PADDING, p);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WIDTH, w);
        @(posedge i_clk);
    endtask

    function automatic void add_row(logic [1:0] op, int oc, int ic, int r, int c,
                                    logic [15:0] v, bit typed = 1'b0, t_rsp want = '0);
        t_row x;
        x.req = '{op: op, out_chan: oc, in_chan: ic, row_index: r, col_index: c, value: v};
        x.typed = typed;
        x.rsp = want;
        rows.push_back(x);
    endfunction

    task automatic walk_rows();
        foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].rsp);
        rows.delete();
    endtask

    // Mostly well-formed traffic: fill what a compute of a random filter needs,
    // then compute its rows. The rest is noise over the whole field ranges.
    task automatic random_traffic(int n);
        t_req q;
        int nr, nc, oc;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 75) begin
                oc = $urandom_range(eff(REG_OUT_CH, 1, 8) - 1);
                if (!find_hole(oc, q)) begin
                    void'(out_shape(nr, nc));
                    q.op = OP_COMPUTE;
                    q.row_index = $urandom_range(99) < 90 ? $urandom_range(nr - 1) : nr;
                end
                case ($urandom_range(5))
                    0: q.value = 16'h8000;
                    1: q.value = 16'h7fff;
                    default: ;
                endcase
            end else begin
                q = $urandom;
                // A compute that would read unwritten entries turns into a bad op.
                if (q.op == OP_COMPUTE && out_shape(nr, nc)
                    && q.out_chan < eff(REG_OUT_CH, 1, 8) && q.row_index < nr
                    && find_hole(q.out_chan, q))
                    q.op = OP_INVALID;
            end
            send(q);
        end
    endtask

    initial begin
        #4_000_000;
        $display("conv2d_multichannel: mismatch");
        $finish;
    end

    initial begin
        regs = '{6'd3, 6'd6, 6'd3, 6'd1, 6'd0, 6'd7, 6'd7};
        req_if.valid = 1'b0;
        req_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: 3 inputs, 6 filters, 3x3 kernel, 7x7 image, 5 output rows.
        // Writes at and past each bound, the bad op, and compute range errors.
        add_row(OP_WEIGHT, 0, 0, 0, 0, 16'h7fff, 1, mk_rsp(0, 0, 0, 0, ST_OK, 1));
        add_row(OP_WEIGHT, 5, 2, 2, 2, 16'h8000, 1, mk_rsp(5, 2, 2, 0, ST_OK, 1));
        add_row(OP_WEIGHT, 6, 0, 0, 0, 16'h1234, 1, mk_rsp(6, 0, 0, 0, ST_RANGE, 1));
        add_row(OP_WEIGHT, 7, 3, 0, 0, 16'h1234, 1, mk_rsp(7, 0, 0, 0, ST_RANGE, 1));
        add_row(OP_WEIGHT, 0, 0, 3, 0, 16'h1234, 1, mk_rsp(0, 3, 0, 0, ST_RANGE, 1));
        add_row(OP_WEIGHT, 0, 7, 63, 31, 16'hffff, 1, mk_rsp(0, 63, 31, 0, ST_RANGE, 1));
        add_row(OP_PIXEL, 0, 2, 6, 6, 16'h8000, 1, mk_rsp(2, 6, 6, 0, ST_OK, 1));
        add_row(OP_PIXEL, 0, 3, 0, 0, 16'h0001, 1, mk_rsp(3, 0, 0, 0, ST_RANGE, 1));
        add_row(OP_PIXEL, 0, 0, 7, 0, 16'h0001, 1, mk_rsp(0, 7, 0, 0, ST_RANGE, 1));
        add_row(OP_PIXEL, 0, 0, 0, 7, 16'h0001, 1, mk_rsp(0, 0, 7, 0, ST_RANGE, 1));
        add_row(OP_PIXEL, 7, 7, 63, 31, 16'h7fff, 1, mk_rsp(7, 63, 31, 0, ST_RANGE, 1));
        add_row(OP_INVALID, 7, 7, 63, 31, 16'hffff, 1, mk_rsp(0, 0, 0, 0, ST_RANGE, 1));
        add_row(OP_COMPUTE, 6, 0, 0, 0, 16'h0, 1, mk_rsp(6, 0, 0, 0, ST_RANGE, 1));
        add_row(OP_COMPUTE, 0, 0, 5, 0, 16'h0, 1, mk_rsp(0, 5, 0, 0, ST_RANGE, 1));
        add_row(OP_COMPUTE, 7, 5, 63, 31, 16'hffff, 1, mk_rsp(7, 63, 0, 0, ST_RANGE, 1));
        walk_rows();

        // Small padded image; a stride of zero acts as one. The response side is
        // held off for a long stretch partway so the block backs up.
        set_geometry(1, 2, 3, 0, 1, 4, 4);
        random_traffic(30);
        hold_reqs++;
        random_traffic(30);

        // Two channels, stride two; the sender drains everything halfway.
        set_geometry(2, 1, 2, 2, 0, 3, 5);
        random_traffic(25);
        drain();
        random_traffic(25);

        tx_idle = 72;
        rx_idle = 14;

        // Zero counts act as one; largest kernel, stride and padding on a 1x1 image.
        set_geometry(0, 0, 7, 7, 3, 1, 1);
        random_traffic(55);

        // Counts above the maximum act as eight, a zero kernel as 1x1. Eight
        // channels of extreme products drive the sum into both saturation limits.
        set_geometry(15, 15, 0, 1, 0, 1, 2);
        for (int j = 0; j < 8; j++) begin
            add_row(OP_WEIGHT, 3, j, 0, 0, 16'h8000);
            add_row(OP_PIXEL, 0, j, 0, 0, 16'h8000);
            add_row(OP_PIXEL, 0, j, 0, 1, 16'h7fff);
        end
        add_row(OP_COMPUTE, 3, 0, 0, 0, 16'h0);
        walk_rows();
        random_traffic(40);

        tx_idle = 0;
        rx_idle = 0;

        // Height above the maximum acts as 32; the width is too narrow for the kernel.
        set_geometry(1, 1, 7, 1, 0, 63, 2);
        add_row(OP_PIXEL, 0, 0, 31, 1, 16'h0101, 1, mk_rsp(0, 31, 1, 0, ST_OK, 1));
        add_row(OP_PIXEL, 0, 0, 32, 0, 16'h0101, 1, mk_rsp(0, 32, 0, 0, ST_RANGE, 1));
        add_row(OP_COMPUTE, 0, 0, 0, 0, 16'h0, 1, mk_rsp(0, 0, 0, 0, ST_GEOM, 1));
        add_row(OP_COMPUTE, 7, 0, 37, 0, 16'h0, 1, mk_rsp(7, 37, 0, 0, ST_GEOM, 1));
        walk_rows();
        random_traffic(20);

        drain();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d requests over six geometries, %0d full output rows computed,",
                 n_reqs, n_rows_done);
        $display("%0d responses checked, %0d left unanswered.", n_rsps, pending_rsp.size());
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("conv2d_multichannel: match");
        end else begin
            $display("conv2d_multichannel: mismatch");
        end
        $finish;
    end

endmodule
